FILE: rtl/gbp_pkg.sv
// Shared types and constants for the gshare/BTB branch predictor.
`default_nettype none
package gbp_pkg;
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_COND = 2'd2;
    localparam logic [1:0] CTR_MAX   = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic        action;
        logic [63:0] pc;
        logic [1:0]  branch_kind;
        logic [63:0] offset;
        logic        prior_prediction;
        logic        actual_taken;
    } item_t;
endpackage
`default_nettype wire

FILE: rtl/gbp_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module gbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/gbp_front.sv
// Front end: accepts items into a two-entry queue.
`default_nettype none
module gbp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire gbp_pkg::item_t in_item,
    output logic                q_valid,
    input  wire logic           q_pop,
    output gbp_pkg::item_t      q_item
);
    import gbp_pkg::*;

    item_t      ent_reg [2];
    logic       rd_reg, wr_reg, rd_next, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg ^ push;
        rd_next  = rd_reg ^ q_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= in_item;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/gbp_back.sv
// Back end: BTB and counter lookup, result, and table update.
`default_nettype none
module gbp_back #(
    parameter int BTB_ENTRIES  = 1024,
    parameter int PHT_ENTRIES  = 256,
    parameter int HISTORY_BITS = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire gbp_pkg::item_t q_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                predicted_taken,
    output logic [63:0]         next_pc,
    output logic                squash
);
    import gbp_pkg::*;

    localparam int BW = $clog2(BTB_ENTRIES);
    localparam int PW = $clog2(PHT_ENTRIES);
    localparam int MAXD = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
    localparam int CW = $clog2(MAXD) + 1;
    localparam int BTBW = 1 + 64 + 1 + 64;

    back_state_t state_reg, state_next;
    item_t       it_reg;
    logic [HISTORY_BITS-1:0] hist_reg, hist_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic        ov_reg;
    logic        pt_reg;
    logic [63:0] np_reg;
    logic        sq_reg;

    logic [BW-1:0] b_addr;
    logic [PW-1:0] p_addr, pht_idx, pht_idx_reg;
    logic          b_we, p_we;
    logic [BTBW-1:0] b_wdata, b_rdata;
    logic [1:0]    p_wdata, p_rdata;

    logic        e_valid, e_cond, hit;
    logic [63:0] e_tag, e_target, target, seq;
    logic        do_upd, is_cond;
    logic        r_taken, r_sq;
    logic [63:0] r_np;
    logic [1:0]  c_new;

    assign {e_valid, e_tag, e_cond, e_target} = b_rdata;
    assign target = it_reg.pc + it_reg.offset;
    assign seq    = it_reg.pc + 64'd4;
    assign hit    = e_valid && (e_tag == it_reg.pc);
    assign is_cond = (it_reg.branch_kind == KIND_COND);
    assign do_upd = it_reg.action && (it_reg.branch_kind != KIND_NONE);

    always_comb
    begin
        logic [63:0] h;
        h = 64'(hist_reg) ^ (q_item.pc >> 2);
        pht_idx = h[PW-1:0];
    end

    gbp_ram #(.WIDTH(BTBW), .DEPTH(BTB_ENTRIES)) u_btb (
        .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
    );
    gbp_ram #(.WIDTH(2), .DEPTH(PHT_ENTRIES)) u_pht (
        .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
    );

    // Result and counter training for the item held in it_reg.
    always_comb
    begin
        r_taken = 1'b0;
        r_sq    = 1'b0;
        r_np    = seq;
        if (!it_reg.action)
        begin
            if (hit && (!e_cond || p_rdata[1]))
            begin
                r_taken = 1'b1;
                r_np    = e_target;
            end
        end
        else if (it_reg.branch_kind != KIND_NONE)
        begin
            r_sq = (it_reg.prior_prediction != it_reg.actual_taken) ||
                   (it_reg.actual_taken && hit && (e_target != target));
            r_np = it_reg.actual_taken ? target : seq;
        end
        c_new = p_rdata;
        if (it_reg.actual_taken)
        begin
            if (p_rdata != CTR_MAX) c_new = p_rdata + 2'd1;
        end
        else if (p_rdata != 2'd0)
        begin
            c_new = p_rdata - 2'd1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == CW'(MAXD - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (q_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_DONE;
            ST_DONE:  if (!ov_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Outputs and memory controls.
    always_comb
    begin
        q_pop     = 1'b0;
        b_we      = 1'b0;
        p_we      = 1'b0;
        b_addr    = q_item.pc[BW+1:2];
        p_addr    = pht_idx;
        b_wdata   = '0;
        p_wdata   = '0;
        hist_next = hist_reg;
        clr_next  = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                b_addr   = clr_reg[BW-1:0];
                p_addr   = clr_reg[PW-1:0];
                b_we     = (clr_reg < CW'(BTB_ENTRIES));
                p_we     = (clr_reg < CW'(PHT_ENTRIES));
                clr_next = clr_reg + CW'(1);
            end
            ST_IDLE:  q_pop = q_valid;
            ST_READ:
            begin
                // Keep the held item's entries on the read ports.
                b_addr = it_reg.pc[BW+1:2];
                p_addr = pht_idx_reg;
            end
            ST_DONE:
            begin
                // Write back once the result slot is free.
                b_addr  = it_reg.pc[BW+1:2];
                p_addr  = pht_idx_reg;
                if (!ov_reg || out_ready)
                begin
                    b_we    = do_upd;
                    p_we    = do_upd && is_cond;
                    b_wdata = hit ? {1'b1, e_tag, e_cond, target}
                                  : {1'b1, it_reg.pc, is_cond, target};
                    p_wdata = c_new;
                    if (do_upd && is_cond)
                        hist_next = {hist_reg[HISTORY_BITS-2:0], it_reg.actual_taken};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            it_reg      <= q_item;
            pht_idx_reg <= pht_idx;
        end
        if (state_reg == ST_DONE && (!ov_reg || out_ready))
        begin
            pt_reg <= r_taken;
            np_reg <= r_np;
            sq_reg <= r_sq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            hist_reg  <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hist_reg  <= hist_next;
            clr_reg   <= clr_next;
            if (state_reg == ST_DONE && (!ov_reg || out_ready))
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid       = ov_reg;
    assign predicted_taken = pt_reg;
    assign next_pc         = np_reg;
    assign squash          = sq_reg;
endmodule
`default_nettype wire

FILE: rtl/gshare_btb_branch_predictor.sv
// Top level: gshare direction predictor with a direct-mapped BTB.
// Path from acceptance to result: queue, pop into the held item register, table read,
// result register. The back end takes a new item only once the last one's write-back
// is done. After reset a clearing pass over max(BTB_ENTRIES, PHT_ENTRIES) addresses
// zeroes both tables; items wait in the two-entry queue until it finishes.
`default_nettype none
module gshare_btb_branch_predictor #(
    parameter int BTB_ENTRIES  = 1024,
    parameter int PHT_ENTRIES  = 256,
    parameter int HISTORY_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [63:0] pc,
    input  wire logic [1:0]  branch_kind,
    input  wire logic [63:0] offset,
    input  wire logic        prior_prediction,
    input  wire logic        actual_taken,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             predicted_taken,
    output logic [63:0]      next_pc,
    output logic             squash
);
    import gbp_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_pop;

    assign in_item = '{action, pc, branch_kind, offset, prior_prediction, actual_taken};

    gbp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    gbp_back #(
        .BTB_ENTRIES(BTB_ENTRIES), .PHT_ENTRIES(PHT_ENTRIES), .HISTORY_BITS(HISTORY_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready), .predicted_taken(predicted_taken),
        .next_pc(next_pc), .squash(squash)
    );
endmodule
`default_nettype wire

FILE: rtl/gbp_checker.sv
// Port-level checker for the branch predictor, bound to the top level.
`default_nettype none
module gbp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        predicted_taken,
    input wire logic        squash,
    input wire logic [63:0] next_pc
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(predicted_taken && squash)) else $error("taken and squash");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc)) else $error("output moved");
    a_sq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(squash)) else $error("squash moved");
endmodule

bind gshare_btb_branch_predictor gbp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .predicted_taken(predicted_taken), .squash(squash), .next_pc(next_pc)
);
`default_nettype wire
